FILE: src/lbd_pkg.sv
// shared types and constants of the length-bounded dag longest-path unit
package lbd_pkg;

    // table geometry
    localparam int NODE_COUNT   = 1024;
    localparam int NODE_W       = 10;
    localparam int LEN_W        = 4;
    localparam int MAX_PATH_LEN = 15;
    localparam int ADDR_W       = LEN_W + NODE_W;
    localparam int TABLE_DEPTH  = (MAX_PATH_LEN + 1) * NODE_COUNT;

    // field widths
    localparam int DIST_W     = 32;
    localparam int PRED_W     = 11;
    localparam int BIN_W      = 11;
    localparam int COST_W     = 24;
    localparam int STEP_W     = 12;
    localparam int SHIFT_W    = 4;
    localparam int DIFF_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // tan(3.14/6) in unsigned q0.32
    localparam logic [31:0] TAN_LIMIT = 32'd2478180410;

    // word function codes
    localparam logic FUNC_RELAX = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_CNT  = 3'd0,
        REG_SRC_LIMIT  = 3'd1,
        REG_MAX_LEN    = 3'd2,
        REG_FREQ_CNT   = 3'd3,
        REG_FREQ_STEP  = 3'd4,
        REG_TIME_SHIFT = 3'd5
    } cfg_idx_t;

    // input word
    typedef struct packed {
        logic                     func;
        logic [NODE_W-1:0]        src_node;
        logic [NODE_W-1:0]        dst_node;
        logic signed [COST_W-1:0] arc_cost;
        logic [LEN_W-1:0]         read_length;
    } in_word_t;

    // output word
    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic [PRED_W-1:0]        predecessor;
    } out_word_t;

    // one table entry
    typedef struct packed {
        logic signed [DIST_W-1:0] dist_val;
        logic [PRED_W-1:0]        pred;
    } entry_t;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [NODE_W-1:0] dividend;
        logic [BIN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [NODE_W-1:0] quo;
        logic [BIN_W-1:0]  rem;
    } div_rsp_t;

    // turn test handshake
    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] u1;
        logic signed [DIFF_W-1:0] v1;
        logic signed [DIFF_W-1:0] u2;
        logic signed [DIFF_W-1:0] v2;
        logic [STEP_W-1:0]        step;
        logic [SHIFT_W-1:0]       shift;
    } turn_req_t;

    typedef struct packed {
        logic done;
        logic sharp;
    } turn_rsp_t;

endpackage

FILE: src/lbd_ram.sv
// generic single-clock ram with one write port and one registered read port
module lbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/lbd_div.sv
// restoring divider, one quotient bit per cycle, node number by bin count
module lbd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lbd_pkg::div_req_t req,
    output lbd_pkg::div_rsp_t rsp
);
    import lbd_pkg::*;

    localparam int CNT_W = $clog2(NODE_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NODE_W-1:0] quo_reg, quo_next;
    logic [BIN_W-1:0]  rem_reg, rem_next;
    logic [BIN_W-1:0]  dsr_reg, dsr_next;
    logic [BIN_W:0]    trial;

    // one trial subtraction a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[NODE_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = BIN_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[NODE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[BIN_W-1:0];
                quo_next = {quo_reg[NODE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NODE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp = '{done: done_reg, quo: quo_reg, rem: rem_reg};

endmodule

FILE: src/lbd_turn.sv
// turn sharpness test by exact cross-multiplication, multi-cycle datapath
module lbd_turn (
    input  logic               clk,
    input  logic               rst_n,
    input  lbd_pkg::turn_req_t req,
    output lbd_pkg::turn_rsp_t rsp
);
    import lbd_pkg::*;

    localparam int PH_W    = 4;
    localparam int MUL_W   = 2 * DIFF_W;
    localparam int CROSS_W = MUL_W + 1;
    localparam int SQ_W    = 2 * STEP_W;
    localparam int NM_W    = STEP_W + 1 + CROSS_W;
    localparam int SQU_W   = SQ_W + 1 + MUL_W;
    localparam int NUM_W   = NM_W + 8 + (1 << SHIFT_W) - 1;
    localparam int NABS_W  = NUM_W + 1;
    localparam int LIMB_W  = 24;
    localparam int DEN_W   = 3 * LIMB_W;
    localparam int PROD_W  = LIMB_W + 32;
    localparam int ACC_W   = DEN_W + 32;
    localparam int LHS_W   = NABS_W - 1 + 32;

    localparam logic [PH_W-1:0] PH_MUL   = 4'd0;
    localparam logic [PH_W-1:0] PH_CROSS = 4'd1;
    localparam logic [PH_W-1:0] PH_SCALE = 4'd2;
    localparam logic [PH_W-1:0] PH_ALIGN = 4'd3;
    localparam logic [PH_W-1:0] PH_SIGN  = 4'd4;
    localparam logic [PH_W-1:0] PH_LIMB0 = 4'd5;
    localparam logic [PH_W-1:0] PH_LIMB1 = 4'd6;
    localparam logic [PH_W-1:0] PH_LIMB2 = 4'd7;
    localparam logic [PH_W-1:0] PH_CMP   = 4'd8;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic                      sharp_reg, sharp_next;
    logic [PH_W-1:0]           ph_reg, ph_next;
    logic signed [DIFF_W-1:0]  u1_reg, u1_next, v1_reg, v1_next;
    logic signed [DIFF_W-1:0]  u2_reg, u2_next, v2_reg, v2_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [SHIFT_W-1:0]        sh_reg, sh_next;
    logic signed [MUL_W-1:0]   m1_reg, m1_next, m2_reg, m2_next;
    logic signed [MUL_W-1:0]   m3_reg, m3_next, m4_reg, m4_next;
    logic signed [CROSS_W-1:0] cross_reg, cross_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic signed [NM_W-1:0]    nm_reg, nm_next;
    logic signed [SQU_W-1:0]   squ_reg, squ_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic signed [DEN_W-1:0]   den_reg, den_next;
    logic signed [NABS_W-1:0]  nabs_reg, nabs_next;
    logic                      zero_reg, zero_next;
    logic [DEN_W-1:0]          dsh_reg, dsh_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [PROD_W-1:0]         prod;
    logic [LHS_W-1:0]          lhs;

    // one limb of |den| times the tangent limit
    assign prod = dsh_reg[DEN_W-1 -: LIMB_W] * TAN_LIMIT;
    assign lhs  = {nabs_reg[NABS_W-2:0], 32'b0};

    // phase sequencer
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        sharp_next = sharp_reg;
        ph_next    = ph_reg;
        u1_next    = u1_reg;
        v1_next    = v1_reg;
        u2_next    = u2_reg;
        v2_next    = v2_reg;
        step_next  = step_reg;
        sh_next    = sh_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        m3_next    = m3_reg;
        m4_next    = m4_reg;
        cross_next = cross_reg;
        sq_next    = sq_reg;
        nm_next    = nm_reg;
        squ_next   = squ_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        nabs_next  = nabs_reg;
        zero_next  = zero_reg;
        dsh_next   = dsh_reg;
        acc_next   = acc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            ph_next   = PH_MUL;
            u1_next   = req.u1;
            v1_next   = req.v1;
            u2_next   = req.u2;
            v2_next   = req.v2;
            step_next = req.step;
            sh_next   = req.shift;
        end
        else if (busy_reg)
        begin
            ph_next = ph_reg + PH_W'(1);
            case (ph_reg)
                // segment slope products
                PH_MUL:
                begin
                    m1_next = u1_reg * v2_reg;
                    m2_next = u2_reg * v1_reg;
                    m3_next = v1_reg * v2_reg;
                    m4_next = u1_reg * u2_reg;
                end
                // cross term and squared step
                PH_CROSS:
                begin
                    cross_next = CROSS_W'(m1_reg) - CROSS_W'(m2_reg);
                    sq_next    = step_reg * step_reg;
                end
                // scale by bin spacing
                PH_SCALE:
                begin
                    nm_next  = $signed({1'b0, step_reg}) * cross_reg;
                    squ_next = $signed({1'b0, sq_reg}) * m4_reg;
                end
                // align time scale into numerator and denominator
                PH_ALIGN:
                begin
                    num_next = NUM_W'(nm_reg) <<< (5'd8 + {1'b0, sh_reg});
                    den_next = (DEN_W'(m3_reg) <<< (6'd16 + {1'b0, sh_reg, 1'b0}))
                             + DEN_W'(squ_reg);
                end
                // fold the denominator sign into the numerator
                PH_SIGN:
                begin
                    zero_next = (den_reg == '0);
                    if (den_reg[DEN_W-1])
                    begin
                        nabs_next = -NABS_W'(num_reg);
                        dsh_next  = -den_reg;
                    end
                    else
                    begin
                        nabs_next = NABS_W'(num_reg);
                        dsh_next  = den_reg;
                    end
                    acc_next = '0;
                end
                // |den| times limit, top limb first
                PH_LIMB0, PH_LIMB1, PH_LIMB2:
                begin
                    acc_next = (acc_reg << LIMB_W) + ACC_W'(prod);
                    dsh_next = dsh_reg << LIMB_W;
                end
                // final compare
                PH_CMP:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    if (zero_reg)
                    begin
                        sharp_next = (num_reg > 0);
                    end
                    else
                    begin
                        sharp_next = !nabs_reg[NABS_W-1] && (nabs_reg != '0)
                                   && (ACC_W'(lhs) > acc_reg);
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            sharp_reg <= 1'b0;
            ph_reg    <= PH_MUL;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            sharp_reg <= sharp_next;
            ph_reg    <= ph_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        u1_reg    <= u1_next;
        v1_reg    <= v1_next;
        u2_reg    <= u2_next;
        v2_reg    <= v2_next;
        step_reg  <= step_next;
        sh_reg    <= sh_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        m3_reg    <= m3_next;
        m4_reg    <= m4_next;
        cross_reg <= cross_next;
        sq_reg    <= sq_next;
        nm_reg    <= nm_next;
        squ_reg   <= squ_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        nabs_reg  <= nabs_next;
        zero_reg  <= zero_next;
        dsh_reg   <= dsh_next;
        acc_reg   <= acc_next;
    end

    assign rsp = '{done: done_reg, sharp: sharp_reg};

endmodule

FILE: src/length_bounded_dag_longest_path_unit.sv
// top level of the length-bounded dag longest-path unit
// After reset the unit sweeps its 16384-entry distance/predecessor table to zero, one entry a
// cycle, and takes no word in that time; configuration writes are taken as always. A read word
// holds the unit while the registered table read completes; its result is then loaded into the
// output register once that register is free, so it waits on out_ready. A relax word whose
// source is below the source limit, with a nonzero max length, first splits source and
// destination into column and bin with two runs of the serial divider, then walks lengths
// 1..max_length, each with the two table reads, the check and the update, or with only the
// reads and the check when the source is unreachable at that length; a length whose source is
// not a start node adds a division of the predecessor and the turn test. The table ram has one
// read and one write port.
module length_bounded_dag_longest_path_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lbd_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [lbd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  lbd_pkg::in_word_t                in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lbd_pkg::out_word_t               out_word
);
    import lbd_pkg::*;

    typedef enum logic [11:0] {
        ST_CLEAR    = 12'b0000_0000_0001,
        ST_IDLE     = 12'b0000_0000_0010,
        ST_RD_WAIT  = 12'b0000_0000_0100,
        ST_DIV_SRC  = 12'b0000_0000_1000,
        ST_DIV_DST  = 12'b0000_0001_0000,
        ST_RD_SRC   = 12'b0000_0010_0000,
        ST_RD_DST   = 12'b0000_0100_0000,
        ST_CHECK    = 12'b0000_1000_0000,
        ST_DIV_PRED = 12'b0001_0000_0000,
        ST_TURN     = 12'b0010_0000_0000,
        ST_UPDATE   = 12'b0100_0000_0000
    } state_t;

    localparam int SUM_W = DIST_W + 1;

    state_t state_reg, state_next;

    // configuration
    logic [BIN_W-1:0]   snc_reg, slim_reg, fcnt_reg;
    logic [LEN_W-1:0]   mlen_reg;
    logic [STEP_W-1:0]  fstep_reg;
    logic [SHIFT_W-1:0] tsh_reg;
    logic [BIN_W-1:0]   fc_eff;

    // sequencing
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               out_valid_reg, out_valid_next;
    logic               div_go_reg, div_go_next;
    logic               turn_go_reg, turn_go_next;

    // payload
    in_word_t                 item_reg, item_next;
    out_word_t                out_word_reg, out_word_next;
    logic [NODE_W-1:0]        div_dvd_reg, div_dvd_next;
    logic [NODE_W-1:0]        sq_reg, sq_next, dq_reg, dq_next;
    logic [BIN_W-1:0]         sr_reg, sr_next, dr_reg, dr_next;
    logic signed [DIST_W-1:0] sdist_reg, sdist_next, old_reg, old_next;
    logic [PRED_W-1:0]        spp_reg, spp_next;
    logic signed [DIFF_W-1:0] tu1_reg, tu1_next, tv1_reg, tv1_next;
    logic signed [DIFF_W-1:0] tu2_reg, tu2_next, tv2_reg, tv2_next;

    // ram ports
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    // helper units
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    turn_req_t turn_req;
    turn_rsp_t turn_rsp;

    // update arithmetic
    logic [PRED_W-1:0]        row0_pred;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] tent;
    logic [SUM_W-1:0]         tent_ext, old_ext, tent_mag, old_mag;
    logic                     last_len;

    assign fc_eff = (fcnt_reg == '0) ? BIN_W'(1) : fcnt_reg;

    // length-zero predecessor comes from the start node count
    assign row0_pred = ({1'b0, item_reg.src_node} < snc_reg)
                     ? ({1'b0, item_reg.src_node} + PRED_W'(1)) : '0;

    // saturating extension of the source path and magnitude compare
    assign sum      = SUM_W'(sdist_reg) + SUM_W'(item_reg.arc_cost);
    assign tent     = (sum[SUM_W-1] != sum[SUM_W-2])
                    ? (sum[SUM_W-1] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}})
                    : sum[DIST_W-1:0];
    assign tent_ext = {tent[DIST_W-1], tent};
    assign old_ext  = {old_reg[DIST_W-1], old_reg};
    assign tent_mag = tent[DIST_W-1] ? -tent_ext : tent_ext;
    assign old_mag  = old_reg[DIST_W-1] ? -old_ext : old_ext;
    assign last_len = (len_reg == mlen_reg);

    // main sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        div_go_next    = 1'b0;
        turn_go_next   = 1'b0;
        item_next      = item_reg;
        out_word_next  = out_word_reg;
        div_dvd_next   = div_dvd_reg;
        sq_next        = sq_reg;
        dq_next        = dq_reg;
        sr_next        = sr_reg;
        dr_next        = dr_reg;
        sdist_next     = sdist_reg;
        old_next       = old_reg;
        spp_next       = spp_reg;
        tu1_next       = tu1_reg;
        tv1_next       = tv1_reg;
        tu2_next       = tu2_reg;
        tv2_next       = tv2_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // clearing sweep after reset
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            // take a word
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_word;
                    if (in_word.func == FUNC_READ)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = {in_word.read_length, in_word.src_node};
                        state_next = ST_RD_WAIT;
                    end
                    else if (({1'b0, in_word.src_node} < slim_reg) && (mlen_reg != '0))
                    begin
                        div_go_next  = 1'b1;
                        div_dvd_next = in_word.src_node;
                        state_next   = ST_DIV_SRC;
                    end
                end
            end
            // read result into the output register
            ST_RD_WAIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.distance    = ram_rdata.dist_val;
                    out_word_next.predecessor = (item_reg.read_length == '0)
                                              ? row0_pred : ram_rdata.pred;
                    state_next               = ST_IDLE;
                end
            end
            // source column and bin
            ST_DIV_SRC:
            begin
                if (div_rsp.done)
                begin
                    sq_next      = div_rsp.quo;
                    sr_next      = div_rsp.rem;
                    div_go_next  = 1'b1;
                    div_dvd_next = item_reg.dst_node;
                    state_next   = ST_DIV_DST;
                end
            end
            // destination column and bin
            ST_DIV_DST:
            begin
                if (div_rsp.done)
                begin
                    dq_next    = div_rsp.quo;
                    dr_next    = div_rsp.rem;
                    len_next   = LEN_W'(1);
                    state_next = ST_RD_SRC;
                end
            end
            // fetch the shorter path at the source
            ST_RD_SRC:
            begin
                ram_re     = 1'b1;
                ram_raddr  = {len_reg - LEN_W'(1), item_reg.src_node};
                state_next = ST_RD_DST;
            end
            // capture source entry, fetch destination entry
            ST_RD_DST:
            begin
                sdist_next = ram_rdata.dist_val;
                spp_next   = (len_reg == LEN_W'(1)) ? row0_pred : ram_rdata.pred;
                ram_re     = 1'b1;
                ram_raddr  = {len_reg, item_reg.dst_node};
                state_next = ST_CHECK;
            end
            // reachability and start node test
            ST_CHECK:
            begin
                old_next = ram_rdata.dist_val;
                if (spp_reg == '0)
                begin
                    len_next   = len_reg + LEN_W'(1);
                    state_next = last_len ? ST_IDLE : ST_RD_SRC;
                end
                else if ({1'b0, item_reg.src_node} >= snc_reg)
                begin
                    div_go_next  = 1'b1;
                    div_dvd_next = NODE_W'(spp_reg - PRED_W'(1));
                    state_next   = ST_DIV_PRED;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            // predecessor column and bin, then segment differences
            ST_DIV_PRED:
            begin
                if (div_rsp.done)
                begin
                    tu1_next     = $signed({1'b0, sr_reg}) - $signed({1'b0, div_rsp.rem});
                    tv1_next     = $signed({2'b0, sq_reg}) - $signed({2'b0, div_rsp.quo});
                    tu2_next     = $signed({1'b0, dr_reg}) - $signed({1'b0, sr_reg});
                    tv2_next     = $signed({2'b0, dq_reg}) - $signed({2'b0, sq_reg});
                    turn_go_next = 1'b1;
                    state_next   = ST_TURN;
                end
            end
            // wait for the turn test
            ST_TURN:
            begin
                if (turn_rsp.done)
                begin
                    if (turn_rsp.sharp)
                    begin
                        len_next   = len_reg + LEN_W'(1);
                        state_next = last_len ? ST_IDLE : ST_RD_SRC;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            // write back when the new magnitude is not smaller
            ST_UPDATE:
            begin
                if (old_mag <= tent_mag)
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = {len_reg, item_reg.dst_node};
                    ram_wdata.dist_val = tent;
                    ram_wdata.pred     = {1'b0, item_reg.src_node} + PRED_W'(1);
                end
                len_next   = len_reg + LEN_W'(1);
                state_next = last_len ? ST_IDLE : ST_RD_SRC;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
            turn_go_reg   <= 1'b0;
            snc_reg       <= '0;
            slim_reg      <= BIN_W'(NODE_COUNT);
            mlen_reg      <= LEN_W'(MAX_PATH_LEN);
            fcnt_reg      <= BIN_W'(1);
            fstep_reg     <= STEP_W'(256);
            tsh_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            div_go_reg    <= div_go_next;
            turn_go_reg   <= turn_go_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_idx))
                    REG_START_CNT:  snc_reg   <= cfg_wdata[BIN_W-1:0];
                    REG_SRC_LIMIT:  slim_reg  <= cfg_wdata[BIN_W-1:0];
                    REG_MAX_LEN:    mlen_reg  <= cfg_wdata[LEN_W-1:0];
                    REG_FREQ_CNT:   fcnt_reg  <= cfg_wdata[BIN_W-1:0];
                    REG_FREQ_STEP:  fstep_reg <= cfg_wdata[STEP_W-1:0];
                    REG_TIME_SHIFT: tsh_reg   <= cfg_wdata[SHIFT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_word_reg <= out_word_next;
        div_dvd_reg  <= div_dvd_next;
        sq_reg       <= sq_next;
        dq_reg       <= dq_next;
        sr_reg       <= sr_next;
        dr_reg       <= dr_next;
        sdist_reg    <= sdist_next;
        old_reg      <= old_next;
        spp_reg      <= spp_next;
        tu1_reg      <= tu1_next;
        tv1_reg      <= tv1_next;
        tu2_reg      <= tu2_next;
        tv2_reg      <= tv2_next;
    end

    assign div_req  = '{start: div_go_reg, dividend: div_dvd_reg, divisor: fc_eff};
    assign turn_req = '{start: turn_go_reg, u1: tu1_reg, v1: tv1_reg, u2: tu2_reg,
                        v2: tv2_reg, step: fstep_reg, shift: tsh_reg};

    // distance and predecessor table
    lbd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // node to column and bin
    lbd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // turn sharpness test
    lbd_turn u_turn (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (turn_req),
        .rsp   (turn_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: src/lbd_chk.sv
// port-level checker for the longest-path unit and its bind
module lbd_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input lbd_pkg::in_word_t  in_word,
    input logic               out_valid,
    input logic               out_ready,
    input lbd_pkg::out_word_t out_word
);
    import lbd_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
        else $error("result word changed while stalled");

    // predecessor is a one-based node number or zero
    a_pred_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.predecessor <= PRED_W'(NODE_COUNT)))
        else $error("predecessor out of range");

    // a read word keeps the unit busy for its table access
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_word.func == FUNC_READ)) |=> !in_ready)
        else $error("word taken during a read");

    // a new result follows a busy cycle
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a read in flight");

endmodule

bind length_bounded_dag_longest_path_unit lbd_chk u_lbd_chk (.*);
